@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CCS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define CCS_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ rtl/ccs_pkg.sv @@
package ccs_pkg;

  localparam int unsigned WinLen = 5;

  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;

  // Slot 0 is the oldest byte of the window.
  typedef logic [WinLen-1:0][7:0] win_t;

  typedef struct packed {
    logic char_literal_open;
    logic string_open;
    logic line_comment_open;
    logic block_comment_open;
    logic line_emitted_any;
    logic line_saw_comment;
  } flags_t;

endpackage

@@ rtl/ccs_ifs.sv @@
interface ccs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface ccs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

@@ rtl/c_comment_stripper.sv @@
// C comment stripper: takes source text one byte per beat and returns the text with line and
// block comments removed, the kept bytes trailing the input by a five-byte window. Each input
// beat gives zero or more output beats, and the last of them carries last_of_run. An ordinary
// byte is shifted into the window and then closes its run. A newline flushes the window with
// up to five shift steps until the window is empty, then decides on the newline and closes the
// run; end of input likewise flushes the window and closes the run without a newline.
// The single shift-and-check unit does one window step per cycle while the output is not
// stalled; no new input byte is taken until the run is closed.
module c_comment_stripper (
  input logic       clk,
  input logic       rst,
  ccs_in_if.sink    text,
  ccs_out_if.source kept
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FLUSH = 4'b0010,
    S_NEWL  = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t          state, state_next;
  ccs_pkg::win_t   win, win_next;
  ccs_pkg::flags_t flags, flags_next;
  logic            nl, nl_next;
  logic            pend_valid, pend_valid_next;
  logic [7:0]      pend_byte, pend_byte_next;
  logic            out_valid;
  logic [7:0]      out_byte_r;
  logic            out_last;

  logic            push, push_last;
  logic            out_free;
  logic            nl_emit;
  logic [7:0]      step_byte;
  ccs_pkg::win_t   step_win;
  ccs_pkg::flags_t step_flags;
  logic            step_emit;
  logic [7:0]      step_emit_byte;

  assign step_byte = (state == S_IDLE) ? text.in_byte : 8'h00;
  assign out_free  = !out_valid || kept.ready;
  assign text.ready = (state == S_IDLE);

  ccs_step u_step (
    .win        (win),
    .flags      (flags),
    .shift_byte (step_byte),
    .win_next   (step_win),
    .flags_next (step_flags),
    .emit_valid (step_emit),
    .emit_byte  (step_emit_byte)
  );

  // A produced byte waits in the pending register until the next one shows it was not the last.
  always_comb begin
    state_next      = state;
    win_next        = win;
    flags_next      = flags;
    nl_next         = nl;
    pend_valid_next = pend_valid;
    pend_byte_next  = pend_byte;
    push            = 1'b0;
    push_last       = 1'b0;
    nl_emit         = flags.line_emitted_any || !flags.line_saw_comment;

    case (state)
      S_IDLE: begin
        if (text.valid) begin
          if (text.end_of_input) begin
            nl_next    = 1'b0;
            state_next = S_FLUSH;
          end else if (text.in_byte == ccs_pkg::CH_NEWLINE) begin
            nl_next    = 1'b1;
            state_next = S_FLUSH;
          end else begin
            win_next   = step_win;
            flags_next = step_flags;
            if (step_emit) begin
              pend_valid_next = 1'b1;
              pend_byte_next  = step_emit_byte;
            end
            state_next = S_FIN;
          end
        end
      end
      S_FLUSH: begin
        if (|win) begin
          if (!(step_emit && pend_valid && !out_free)) begin
            win_next   = step_win;
            flags_next = step_flags;
            if (step_emit) begin
              push            = pend_valid;
              pend_valid_next = 1'b1;
              pend_byte_next  = step_emit_byte;
            end
          end
        end else begin
          state_next = nl ? S_NEWL : S_FIN;
        end
      end
      S_NEWL: begin
        if (!(nl_emit && pend_valid && !out_free)) begin
          if (nl_emit) begin
            push            = pend_valid;
            pend_valid_next = 1'b1;
            pend_byte_next  = ccs_pkg::CH_NEWLINE;
          end
          flags_next.line_emitted_any  = 1'b0;
          flags_next.line_saw_comment  = 1'b0;
          flags_next.line_comment_open = 1'b0;
          flags_next.char_literal_open = 1'b0;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          push            = 1'b1;
          push_last       = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      win        <= '0;
      flags      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      win        <= win_next;
      flags      <= flags_next;
      pend_valid <= pend_valid_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (kept.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    nl        <= nl_next;
    pend_byte <= pend_byte_next;
    if (push) begin
      out_byte_r <= pend_byte;
      out_last   <= push_last;
    end
  end

  assign kept.valid       = out_valid;
  assign kept.out_byte    = out_byte_r;
  assign kept.last_of_run = out_last;

endmodule

@@ rtl/ccs_step.sv @@
// One shift of the delay window followed by the opening and closing checks.
module ccs_step (
  input  ccs_pkg::win_t   win,
  input  ccs_pkg::flags_t flags,
  input  logic [7:0]      shift_byte,
  output ccs_pkg::win_t   win_next,
  output ccs_pkg::flags_t flags_next,
  output logic            emit_valid,
  output logic [7:0]      emit_byte
);

  ccs_pkg::win_t w;
  logic          comment_now;

  always_comb begin
    emit_byte  = win[0];
    emit_valid = (win[0] != 8'h00) && !(flags.line_comment_open || flags.block_comment_open);

    flags_next = flags;
    if (emit_valid) begin
      flags_next.line_emitted_any = 1'b1;
    end

    w = {shift_byte, win[ccs_pkg::WinLen-1:1]};

    // Only the first check that matches acts.
    if (flags.char_literal_open) begin
      if (w[2] == ccs_pkg::CH_SQUOTE) begin
        flags_next.char_literal_open = 1'b0;
      end
    end else if (w[0] == ccs_pkg::CH_SLASH && w[1] == ccs_pkg::CH_SLASH) begin
      flags_next.line_comment_open = !(flags.block_comment_open || flags.string_open);
    end else if (w[0] == ccs_pkg::CH_SLASH && w[1] == ccs_pkg::CH_STAR) begin
      flags_next.block_comment_open = !(flags.line_comment_open || flags.string_open);
    end else if (w[0] == ccs_pkg::CH_STAR && w[1] == ccs_pkg::CH_SLASH) begin
      if (flags.block_comment_open) begin
        flags_next.block_comment_open = 1'b0;
        w[0] = 8'h00;
        w[1] = 8'h00;
      end
    end else if (w[0] != ccs_pkg::CH_BACKSLASH && w[1] == ccs_pkg::CH_SQUOTE &&
                 (w[3] == ccs_pkg::CH_SQUOTE ||
                  (w[2] == ccs_pkg::CH_BACKSLASH && w[4] == ccs_pkg::CH_SQUOTE))) begin
      if (!(flags.line_comment_open || flags.block_comment_open)) begin
        flags_next.char_literal_open = 1'b1;
      end
    end else if (w[0] != ccs_pkg::CH_BACKSLASH && w[1] == ccs_pkg::CH_DQUOTE) begin
      flags_next.string_open = !(flags.string_open || flags.line_comment_open ||
                                 flags.block_comment_open);
    end

    comment_now = flags_next.line_comment_open || flags_next.block_comment_open;
    if (comment_now) begin
      flags_next.line_saw_comment = 1'b1;
    end

    win_next = w;
  end

endmodule

@@ rtl/ccs_checker.sv @@
`include "assert_macros.svh"

module ccs_checker (
  input logic       clk,
  input logic       rst,
  input logic       text_valid,
  input logic       text_ready,
  input logic       kept_valid,
  input logic       kept_ready,
  input logic [7:0] out_byte,
  input logic       last_of_run
);

  // A beat left waiting must keep its payload.
  `CCS_ASSERT(a_out_hold, kept_valid && !kept_ready |=> kept_valid && $stable(out_byte) && $stable(last_of_run), "stalled output beat changed")

  // The block works on one item at a time, so it is busy after taking a beat.
  `CCS_ASSERT(a_busy_after_accept, text_valid && text_ready |=> !text_ready, "input taken on two cycles in a row")

  // Zero bytes are empty window slots and never leave the block.
  `CCS_NEVER(a_no_zero_out, kept_valid && out_byte == 8'h00, "zero byte on the output")

  // A newline only ever closes the run of the beat that caused it.
  `CCS_NEVER(a_newline_last, kept_valid && out_byte == 8'h0A && !last_of_run, "newline not last of run")

endmodule

bind c_comment_stripper ccs_checker u_ccs_checker (
  .clk         (clk),
  .rst         (rst),
  .text_valid  (text.valid),
  .text_ready  (text.ready),
  .kept_valid  (kept.valid),
  .kept_ready  (kept.ready),
  .out_byte    (kept.out_byte),
  .last_of_run (kept.last_of_run)
);
